### rtl/ncst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncst_pkg: shared types and constants
// Request and status codes, table sizes, controller/datapath command bundle.
// ----------------------------------------------------------------------------
package ncst_pkg;

	localparam int SLOTS      = 16;
	localparam int SLOT_BITS  = 4;
	localparam int QCAP       = 8;
	localparam int Q_BITS     = 3;
	localparam int COUNT_BITS = 16;
	localparam int TASK_BITS  = 8;
	localparam int NAME_BYTES = 32;
	localparam int REFS_MAX   = 255;

	typedef enum logic [2:0] {
		REQ_OPEN     = 3'd0,
		REQ_CLOSE    = 3'd1,
		REQ_UNLINK   = 3'd2,
		REQ_WAIT     = 3'd3,
		REQ_TRYWAIT  = 3'd4,
		REQ_POST     = 3'd5,
		REQ_GETVALUE = 3'd6,
		REQ_FORGET   = 3'd7
	} req_t;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_BAD_NAME  = 4'd1,
		ST_EXISTS    = 4'd2,
		ST_NOT_FOUND = 4'd3,
		ST_FULL      = 4'd4,
		ST_UNUSED    = 4'd5,
		ST_EMPTY     = 4'd6,
		ST_QFULL     = 4'd7,
		ST_BLOCKED   = 4'd8,
		ST_OVERFLOW  = 4'd9
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic                 load;      // capture request
		logic                 scan_clr;  // reset scan match
		logic                 scan_step; // compare one slot
		logic                 fgt_step;  // forget one slot's queue
		logic                 exec;      // apply request, form status
		logic                 wake_step; // capture wake task at qidx
		logic [SLOT_BITS-1:0] idx;       // scan slot
		logic [Q_BITS-1:0]    qidx;      // wake index
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		req_t              req;
		logic              q_live;    // queued task at qidx is live
		logic [Q_BITS:0]   q_len;     // queue length of posted entry
		logic              post_ok;   // post will succeed
	} stat_t;

	// canonical name: bytes after terminator zeroed
	function automatic logic [8*NAME_BYTES-1:0] canon_name(input logic [255:0] raw);
		logic [8*NAME_BYTES-1:0] w;
		logic                    done;
		w    = '0;
		done = 1'b0;
		for (int j = 0; j < NAME_BYTES; j++) begin
			if (raw[8*j +: 8] == 8'd0) done = 1'b1;
			if (!done) w[8*j +: 8] = raw[8*j +: 8];
		end
		return w;
	endfunction

	function automatic logic name_ok(input logic [255:0] raw);
		logic found;
		found = 1'b0;
		for (int j = 0; j < NAME_BYTES; j++)
			if (raw[8*j +: 8] == 8'd0) found = 1'b1;
		return found && (raw[7:0] != 8'd0);
	endfunction

endpackage

### rtl/named_counting_semaphore_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// named_counting_semaphore_table_top: table of named counting semaphores
// Controller + datapath; one request at a time.
// ----------------------------------------------------------------------------
// Sequence: request accepted, 16-slot scan of name compare or forget, one
//   execute step, then status, held until output is ready.
// A post that will succeed first walks its wait queue, giving a wake item per live task.
// A new request is accepted only after the previous status has been taken.
// Reset: arst_n clears entry valid/unlinked flags and the sequencer; tables
//   are written before use.
module named_counting_semaphore_table_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: req_type[2:0] handle[6:3] name_word0..3[262:7] create_flag[263]
	//        exclusive_flag[264] initial_count[280:265] task_id[288:281]
	input  logic [295:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: status[3:0] handle_out[7:4] count_out[23:8] wake_task[31:24]
	output logic [31:0]  m_tdata,
	// tuser: wake_valid
	output logic         m_tuser,
	output logic         m_tlast
);
	ncst_pkg::cmd_t  cmd;
	ncst_pkg::stat_t stat;
	logic            wake;
	logic [3:0]      r_status, r_handle, r_whandle;
	logic [15:0]     r_count;
	logic [7:0]      r_task;

	ncst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_wake(wake),
		.cmd(cmd), .stat(stat)
	);

	ncst_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.req_type(s_tdata[2:0]), .handle(s_tdata[6:3]),
		.name_raw(s_tdata[262:7]), .create_flag(s_tdata[263]),
		.exclusive_flag(s_tdata[264]), .initial_count(s_tdata[280:265]),
		.task_id(s_tdata[288:281]),
		.res_status(r_status), .res_handle(r_handle),
		.res_count(r_count), .res_wake_task(r_task),
		.res_wake_handle(r_whandle)
	);

	// wake items carry the posted handle and task, status fields zero
	assign m_tdata = wake ? {r_task, 16'd0, r_whandle, 4'd0}
	                      : {8'd0, r_count, r_handle, r_status};
	assign m_tuser = wake;
	assign m_tlast = !wake;
endmodule

### rtl/ncst_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncst_datapath: semaphore table storage and update
// Holds entries, names and wait queues; scans names and forget one slot a cycle.
// ----------------------------------------------------------------------------
module ncst_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ncst_pkg::cmd_t                    cmd,
	output ncst_pkg::stat_t                   stat,
	input  logic [2:0]                        req_type,
	input  logic [3:0]                        handle,
	input  logic [255:0]                      name_raw,
	input  logic                              create_flag,
	input  logic                              exclusive_flag,
	input  logic [15:0]                       initial_count,
	input  logic [7:0]                        task_id,
	output logic [3:0]                        res_status,
	output logic [3:0]                        res_handle,
	output logic [15:0]                       res_count,
	output logic [7:0]                        res_wake_task,
	output logic [3:0]                        res_wake_handle
);
	localparam int NW = 8 * ncst_pkg::NAME_BYTES;

	logic [ncst_pkg::SLOTS-1:0]          in_use_q, unl_q;
	logic [ncst_pkg::COUNT_BITS-1:0]     count_q [ncst_pkg::SLOTS];
	logic [7:0]                          refs_q  [ncst_pkg::SLOTS];
	logic [NW-1:0]                       names_q [ncst_pkg::SLOTS];
	logic [ncst_pkg::Q_BITS:0]           qlen_q  [ncst_pkg::SLOTS];
	// one word per entry holds its whole wait queue
	logic [ncst_pkg::QCAP-1:0][ncst_pkg::TASK_BITS-1:0] qtask_q [ncst_pkg::SLOTS];
	logic [ncst_pkg::QCAP-1:0]           qlive_q [ncst_pkg::SLOTS];

	ncst_pkg::req_t                      req_q;
	logic [3:0]                          h_q;
	logic [NW-1:0]                       name_q;
	logic                                nok_q, cre_q, exc_q;
	logic [15:0]                         init_q;
	logic [ncst_pkg::TASK_BITS-1:0]      task_q;
	logic                                hit_q;
	logic [ncst_pkg::SLOT_BITS-1:0]      hit_idx_q;

	logic                                h_valid;
	logic [ncst_pkg::SLOT_BITS-1:0]      free_idx;
	logic                                free_any;

	assign h_valid = in_use_q[h_q];
	assign stat.req     = req_q;
	assign stat.q_live  = qlive_q[h_q][cmd.qidx];
	assign stat.q_len   = qlen_q[h_q];
	assign stat.post_ok = h_valid && (count_q[h_q] != '1);
	assign res_wake_handle = h_q;

	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = ncst_pkg::SLOTS - 1; i >= 0; i--)
			if (!in_use_q[i]) begin
				free_idx = ncst_pkg::SLOT_BITS'(i);
				free_any = 1'b1;
			end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			unl_q    <= '0;
			hit_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				req_q  <= ncst_pkg::req_t'(req_type);
				h_q    <= handle;
				name_q <= ncst_pkg::canon_name(name_raw);
				nok_q  <= ncst_pkg::name_ok(name_raw);
				cre_q  <= create_flag;
				exc_q  <= exclusive_flag;
				init_q <= initial_count;
				task_q <= task_id[ncst_pkg::TASK_BITS-1:0];
			end
			if (cmd.scan_clr) hit_q <= 1'b0;
			if (cmd.scan_step && !hit_q && in_use_q[cmd.idx] && !unl_q[cmd.idx]
			    && names_q[cmd.idx] == name_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= cmd.idx;
			end
			if (cmd.fgt_step && in_use_q[cmd.idx]) begin
				for (int q = 0; q < ncst_pkg::QCAP; q++)
					if ((ncst_pkg::Q_BITS+1)'(q) < qlen_q[cmd.idx] &&
					    qtask_q[cmd.idx][q] == task_q)
						qlive_q[cmd.idx][q] <= 1'b0;
			end
			if (cmd.wake_step) res_wake_task <= qtask_q[h_q][cmd.qidx];
			if (cmd.exec) begin
				res_status <= ncst_pkg::ST_OK;
				res_handle <= '0;
				res_count  <= '0;
				case (req_q)
					ncst_pkg::REQ_OPEN, ncst_pkg::REQ_UNLINK: begin
						if (!nok_q) res_status <= ncst_pkg::ST_BAD_NAME;
						else if (req_q == ncst_pkg::REQ_UNLINK) begin
							if (!hit_q) res_status <= ncst_pkg::ST_NOT_FOUND;
							else begin
								unl_q[hit_idx_q] <= 1'b1;
								if (refs_q[hit_idx_q] == 8'd0) in_use_q[hit_idx_q] <= 1'b0;
							end
						end else if (hit_q) begin
							if (cre_q && exc_q) res_status <= ncst_pkg::ST_EXISTS;
							else if (refs_q[hit_idx_q] == 8'(ncst_pkg::REFS_MAX))
								res_status <= ncst_pkg::ST_OVERFLOW;
							else begin
								refs_q[hit_idx_q] <= refs_q[hit_idx_q] + 8'd1;
								res_handle        <= hit_idx_q;
							end
						end else if (!cre_q) res_status <= ncst_pkg::ST_NOT_FOUND;
						else if (!free_any) res_status <= ncst_pkg::ST_FULL;
						else begin
							names_q[free_idx]  <= name_q;
							in_use_q[free_idx] <= 1'b1;
							unl_q[free_idx]    <= 1'b0;
							count_q[free_idx]  <= init_q;
							refs_q[free_idx]   <= 8'd1;
							qlen_q[free_idx]   <= '0;
							res_handle         <= free_idx;
						end
					end
					ncst_pkg::REQ_FORGET: ;
					default: begin
						if (!h_valid) res_status <= ncst_pkg::ST_UNUSED;
						else case (req_q)
							ncst_pkg::REQ_CLOSE: begin
								if (refs_q[h_q] != 8'd0) refs_q[h_q] <= refs_q[h_q] - 8'd1;
								if (refs_q[h_q] <= 8'd1 && unl_q[h_q]) in_use_q[h_q] <= 1'b0;
							end
							ncst_pkg::REQ_WAIT: begin
								if (count_q[h_q] != '0) count_q[h_q] <= count_q[h_q] - 1'b1;
								else if (qlen_q[h_q] == (ncst_pkg::Q_BITS+1)'(ncst_pkg::QCAP))
									res_status <= ncst_pkg::ST_QFULL;
								else begin
									qtask_q[h_q][qlen_q[h_q][ncst_pkg::Q_BITS-1:0]] <= task_q;
									qlive_q[h_q][qlen_q[h_q][ncst_pkg::Q_BITS-1:0]] <= 1'b1;
									qlen_q[h_q] <= qlen_q[h_q] + 1'b1;
									res_status  <= ncst_pkg::ST_BLOCKED;
								end
							end
							ncst_pkg::REQ_TRYWAIT: begin
								if (count_q[h_q] == '0) res_status <= ncst_pkg::ST_EMPTY;
								else count_q[h_q] <= count_q[h_q] - 1'b1;
							end
							ncst_pkg::REQ_POST: begin
								if (count_q[h_q] == '1) res_status <= ncst_pkg::ST_OVERFLOW;
								else begin
									count_q[h_q] <= count_q[h_q] + 1'b1;
									qlen_q[h_q]  <= '0;
								end
							end
							default: res_count <= 16'(count_q[h_q]);
						endcase
					end
				endcase
			end
		end
	end
endmodule

### rtl/ncst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncst_ctrl: request sequencer
// Accepts a request, drives scans, wakes and the final status handshake.
// ----------------------------------------------------------------------------
module ncst_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            out_wake,
	output ncst_pkg::cmd_t  cmd,
	input  ncst_pkg::stat_t stat
);
	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EXEC, S_WPICK, S_WOUT, S_STAT} state_t;

	state_t                         state_q;
	logic [ncst_pkg::SLOT_BITS:0]   idx_q;
	logic [ncst_pkg::Q_BITS:0]      qi_q;
	logic [ncst_pkg::Q_BITS:0]      qn_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_WOUT) || (state_q == S_STAT);
	assign out_wake  = (state_q == S_WOUT);

	always_comb begin
		cmd           = '0;
		cmd.load      = in_valid && in_ready;
		cmd.scan_clr  = cmd.load;
		cmd.idx       = idx_q[ncst_pkg::SLOT_BITS-1:0];
		cmd.qidx      = qi_q[ncst_pkg::Q_BITS-1:0];
		cmd.scan_step = (state_q == S_SCAN) && stat.req != ncst_pkg::REQ_FORGET;
		cmd.fgt_step  = (state_q == S_SCAN) && stat.req == ncst_pkg::REQ_FORGET;
		cmd.exec      = (state_q == S_EXEC);
		cmd.wake_step = (state_q == S_WPICK) && qi_q < qn_q && stat.q_live;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			qi_q    <= '0;
			qn_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					idx_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == (ncst_pkg::SLOT_BITS+1)'(ncst_pkg::SLOTS - 1)) begin
						qi_q    <= '0;
						qn_q    <= stat.q_len;
						state_q <= (stat.req == ncst_pkg::REQ_POST && stat.post_ok)
						           ? S_WPICK : S_EXEC;
					end
				end
				S_WPICK: begin
					if (qi_q >= qn_q) state_q <= S_EXEC;
					else if (stat.q_live) state_q <= S_WOUT;
					else qi_q <= qi_q + 1'b1;
				end
				S_WOUT: if (out_ready) begin
					qi_q    <= qi_q + 1'b1;
					state_q <= S_WPICK;
				end
				S_EXEC: state_q <= S_STAT;
				S_STAT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("ready while output pending");
	a_exec_stat: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |=> state_q == S_STAT) else $error("exec not followed by status");
	a_wake_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_wake |-> qi_q < qn_q) else $error("wake past queue end");
endmodule
